// ===== rtl/lpss_pkg.sv =====
// ----------------------------------------------------------------------------
// lpss_pkg
// Shared types and constants for the latency percentile statistics unit.
// ----------------------------------------------------------------------------
package lpss_pkg;

  localparam int MAX_SAMPLES_DEF = 256;
  localparam int SAMPLE_W        = 32;
  localparam int COUNT_OUT_W     = 9;

  localparam int PCT_95   = 95;
  localparam int PCT_99   = 99;
  localparam int PCT_BASE = 100;

  // floor(2^22 / 100), exact to one correction step for products below 1e8
  localparam int RECIP_M  = 41943;
  localparam int RECIP_SH = 22;
  localparam int RECIP_W  = 16;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== rtl/lpss_cell.sv =====
// ----------------------------------------------------------------------------
// lpss_cell
// One stage of the sorting chain: holds one sample, takes part in insertion
// and shifts towards the head during readout.
// ----------------------------------------------------------------------------
module lpss_cell import lpss_pkg::*; (
  input  logic                clk,
  input  cell_ctrl_t          ctrl,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                occ,
  input  logic                prev_gt,
  input  logic [SAMPLE_W-1:0] prev_val,
  input  logic [SAMPLE_W-1:0] next_val,
  output logic [SAMPLE_W-1:0] val,
  output logic                gt
);

  // empty cells behave as larger than any sample
  assign gt = !occ || (val > sample);

  always_ff @(posedge clk) begin
    if (ctrl.insert && gt) begin
      val <= prev_gt ? prev_val : sample;
    end else if (ctrl.shift) begin
      val <= next_val;
    end
  end

endmodule

// ===== rtl/lpss_div.sv =====
// ----------------------------------------------------------------------------
// lpss_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lpss_div import lpss_pkg::*; #(
  parameter int DVD_W = 40,
  parameter int DVS_W = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DVD_W);

  logic [DVD_W-1:0]  quo;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;
  logic [STEP_W-1:0] step;
  logic              running;

  logic [DVS_W:0] trial;
  logic [DVS_W:0] diff;
  logic           ge;

  assign trial    = {rem, quo[DVD_W-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign diff     = trial - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else if (start) begin
      running <= 1'b1;
      done    <= 1'b0;
      quo     <= dividend;
      dvs     <= divisor;
      rem     <= '0;
      step    <= '0;
    end else if (running) begin
      rem  <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo  <= {quo[DVD_W-2:0], ge};
      step <= step + STEP_W'(1);
      if (step == STEP_W'(DVD_W - 1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/latency_percentile_stats_unit.sv =====
// ----------------------------------------------------------------------------
// latency_percentile_stats_unit
// Batch latency statistics: count, mean, median, p95 and p99.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle (start high, busy low) into a chain of
// MAX_SAMPLES cells that keeps them sorted on arrival; samples beyond
// capacity are dropped and flagged. The item marked last closes the batch:
// busy then stays high while states S_RK0 to S_RK3 work out the ranks, the
// chain shifts its contents past the head one cell per cycle and a
// bit-serial divider forms the mean in parallel; busy falls once both the
// readout and the mean are done. The result is shown for one cycle with done
// high and cannot be held off; the next batch may start in that same cycle.
// ----------------------------------------------------------------------------
module latency_percentile_stats_unit import lpss_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [SAMPLE_W-1:0]    sample_ns,
  input  logic                   last,
  output logic                   done,
  output logic [COUNT_OUT_W-1:0] sample_count,
  output logic [SAMPLE_W-1:0]    mean_ns,
  output logic [SAMPLE_W-1:0]    median_ns,
  output logic [SAMPLE_W-1:0]    p95_ns,
  output logic [SAMPLE_W-1:0]    p99_ns,
  output logic                   dropped
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = SAMPLE_W + $clog2(MAX_SAMPLES);
  localparam int XW    = CNT_W + 7;
  localparam int PW    = XW + RECIP_W;

  typedef enum logic [2:0] {
    S_IDLE, S_RK0, S_RK1, S_RK2, S_RK3, S_READ, S_WAIT
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [SUM_W-1:0]  sum;
  logic              ovf;
  logic [XW-1:0]     x95, x99;
  logic [CNT_W-1:0]  q95, q99;
  logic [XW-1:0]     rem95, rem99;
  logic [CNT_W-1:0]  r50, r95, r99;
  logic [CNT_W-1:0]  k;

  logic [PW-1:0]     prod95, prod99;
  logic [CNT_W-1:0]  q95_fix, q99_fix, nm1;
  logic              room;
  logic              accept;
  cell_ctrl_t        ctrl;

  logic [SAMPLE_W-1:0] val [MAX_SAMPLES];
  logic                gt  [MAX_SAMPLES];

  logic             div_done;
  logic [SUM_W-1:0] div_q;

  assign busy   = state != S_IDLE;
  assign accept = start && !busy;
  assign room   = count < CNT_W'(MAX_SAMPLES);
  assign ctrl.insert = accept && room;
  assign ctrl.shift  = state == S_READ;

  assign prod95  = PW'(x95) * PW'(RECIP_M);
  assign prod99  = PW'(x99) * PW'(RECIP_M);
  assign nm1     = count - CNT_W'(1);
  assign q95_fix = (rem95 >= XW'(PCT_BASE)) ? q95 + CNT_W'(1) : q95;
  assign q99_fix = (rem99 >= XW'(PCT_BASE)) ? q99 + CNT_W'(1) : q99;

  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    logic                occ;
    logic                pgt;
    logic [SAMPLE_W-1:0] pval;
    logic [SAMPLE_W-1:0] nval;

    assign occ = count > CNT_W'(i);
    if (i == 0) begin : g_head
      assign pgt  = 1'b0;
      assign pval = '0;
    end else begin : g_body
      assign pgt  = gt[i-1];
      assign pval = val[i-1];
    end
    if (i == MAX_SAMPLES - 1) begin : g_tail
      assign nval = '0;
    end else begin : g_inner
      assign nval = val[i+1];
    end

    lpss_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .sample   (sample_ns),
      .occ      (occ),
      .prev_gt  (pgt),
      .prev_val (pval),
      .next_val (nval),
      .val      (val[i]),
      .gt       (gt[i])
    );
  end

  lpss_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_RK0),
    .dividend (sum),
    .divisor  (count),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      sum   <= '0;
      ovf   <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            if (room) begin
              count <= count + CNT_W'(1);
              sum   <= sum + SUM_W'(sample_ns);
            end else begin
              ovf <= 1'b1;
            end
            if (last) begin
              state <= S_RK0;
            end
          end
        end
        S_RK0: begin
          x95   <= XW'(count) * XW'(PCT_95);
          x99   <= XW'(count) * XW'(PCT_99);
          r50   <= count >> 1;
          state <= S_RK1;
        end
        S_RK1: begin
          q95   <= prod95[RECIP_SH +: CNT_W];
          q99   <= prod99[RECIP_SH +: CNT_W];
          state <= S_RK2;
        end
        S_RK2: begin
          rem95 <= x95 - XW'(q95) * XW'(PCT_BASE);
          rem99 <= x99 - XW'(q99) * XW'(PCT_BASE);
          state <= S_RK3;
        end
        S_RK3: begin
          r95   <= (q95_fix < nm1) ? q95_fix : nm1;
          r99   <= (q99_fix < nm1) ? q99_fix : nm1;
          k     <= '0;
          state <= S_READ;
        end
        S_READ: begin
          if (k == r50) median_ns <= val[0];
          if (k == r95) p95_ns    <= val[0];
          if (k == r99) p99_ns    <= val[0];
          k <= k + CNT_W'(1);
          if (k == nm1) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (div_done) begin
            sample_count <= COUNT_OUT_W'(count);
            mean_ns      <= div_q[SAMPLE_W-1:0];
            dropped      <= ovf;
            done         <= 1'b1;
            count        <= '0;
            sum          <= '0;
            ovf          <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_WAIT))
    else $error("result strobe without a closing batch");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_SAMPLES))
    else $error("kept count above capacity");

  a_rank_order: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> (r50 <= r95) && (r95 <= r99) && (r99 <= nm1))
    else $error("percentile ranks out of order");

  a_read_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_RK0 |-> count != '0)
    else $error("batch closed with no kept samples");

endmodule
